### hdl/clat_pkg.sv
// Shared types and constants for the command line argument tokenizer.
package clat_pkg;

  localparam int RUN_LIMIT_DEF  = 32;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_END_ARG  = 2'd1,
    KIND_END_LINE = 2'd2
  } kind_e;

  // What follows the held backslashes of one command.
  typedef enum logic [2:0] {
    TAIL_NONE,
    TAIL_CHAR,
    TAIL_EARG,
    TAIL_EARG_ELINE,
    TAIL_ELINE
  } tail_e;

  localparam int TAIL_W = $bits(tail_e);

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

### hdl/clat_front.sv
// Front end: parses characters, tracks quote/backslash state, issues commands.
module clat_front import clat_pkg::*; #(
  parameter int RUN_LIMIT = RUN_LIMIT_DEF,
  localparam int SW = $clog2(RUN_LIMIT + 1),
  localparam int PW = $clog2(RUN_LIMIT + 3)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    ch_i,
  output logic          cmd_valid_o,
  output logic [SW-1:0] cmd_nslash_o,
  output logic [PW-1:0] cmd_last_pos_o,
  output tail_e         cmd_tail_o,
  output logic [7:0]    cmd_char_o
);

  logic          in_arg_q, in_arg_d;
  logic          in_quotes_q, in_quotes_d;
  logic          pend_q, pend_d;
  logic [SW-1:0] run_q, run_d;

  logic          use_arg;
  logic [SW-1:0] r;
  logic          q;
  logic [SW-1:0] nslash;
  tail_e         tail;
  logic [7:0]    chr;
  logic [PW-1:0] ntail;

  always_comb begin
    in_arg_d    = in_arg_q;
    in_quotes_d = in_quotes_q;
    pend_d      = pend_q;
    run_d       = run_q;
    nslash      = '0;
    tail        = TAIL_NONE;
    chr         = CH_NUL;
    use_arg     = 1'b1;
    r           = run_q;
    q           = in_quotes_q;

    if (pend_q) begin
      pend_d      = 1'b0;
      in_quotes_d = 1'b0;
      q           = 1'b0;
      if (ch_i == CH_DQUOTE) begin
        tail    = TAIL_CHAR;
        chr     = CH_DQUOTE;
        use_arg = 1'b0;
      end
    end else if (!in_arg_q) begin
      r = '0;
      if (ch_i == CH_NUL) begin
        tail        = TAIL_ELINE;
        in_arg_d    = 1'b0;
        in_quotes_d = 1'b0;
        run_d       = '0;
        use_arg     = 1'b0;
      end else if (is_sep(ch_i)) begin
        use_arg = 1'b0;
      end else begin
        in_arg_d    = 1'b1;
        in_quotes_d = 1'b0;
        q           = 1'b0;
        run_d       = '0;
      end
    end

    if (use_arg) begin
      if (ch_i == CH_BSLASH) begin
        run_d = (r < SW'(RUN_LIMIT)) ? r + 1'b1 : r;
      end else if (ch_i == CH_DQUOTE) begin
        nslash = r >> 1;
        run_d  = '0;
        if (r[0]) begin
          tail = TAIL_CHAR;
          chr  = CH_DQUOTE;
        end else if (q) begin
          pend_d = 1'b1;
        end else begin
          in_quotes_d = 1'b1;
        end
      end else begin
        nslash = r;
        run_d  = '0;
        if (ch_i == CH_NUL) begin
          tail        = TAIL_EARG_ELINE;
          in_arg_d    = 1'b0;
          in_quotes_d = 1'b0;
          pend_d      = 1'b0;
        end else if (!q && is_sep(ch_i)) begin
          tail     = TAIL_EARG;
          in_arg_d = 1'b0;
        end else begin
          tail = TAIL_CHAR;
          chr  = ch_i;
        end
      end
    end
  end

  always_comb begin
    case (tail)
      TAIL_NONE:       ntail = PW'(0);
      TAIL_EARG_ELINE: ntail = PW'(2);
      default:         ntail = PW'(1);
    endcase
  end

  assign cmd_valid_o    = accept_i && ((nslash != '0) || (tail != TAIL_NONE));
  assign cmd_nslash_o   = nslash;
  assign cmd_last_pos_o = PW'(nslash) + ntail - PW'(1);
  assign cmd_tail_o     = tail;
  assign cmd_char_o     = chr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_arg_q    <= 1'b0;
      in_quotes_q <= 1'b0;
      pend_q      <= 1'b0;
      run_q       <= '0;
    end else if (accept_i) begin
      in_arg_q    <= in_arg_d;
      in_quotes_q <= in_quotes_d;
      pend_q      <= pend_d;
      run_q       <= run_d;
    end
  end

endmodule

### hdl/clat_fifo.sv
// Small register queue carrying commands from the front end to the back end.
module clat_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hdl/clat_back.sv
// Back end: expands one command into result transactions, one per cycle while results are popped.
module clat_back import clat_pkg::*; #(
  parameter int RUN_LIMIT = RUN_LIMIT_DEF,
  localparam int SW = $clog2(RUN_LIMIT + 1),
  localparam int PW = $clog2(RUN_LIMIT + 3)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  logic [SW-1:0] cmd_nslash_i,
  input  logic [PW-1:0] cmd_last_pos_i,
  input  tail_e         cmd_tail_i,
  input  logic [7:0]    cmd_char_i,
  output logic          cmd_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    out_char_o,
  output logic [1:0]    kind_o,
  output logic          last_o
);

  logic          ovalid_q;
  logic [PW-1:0] pos_q;
  logic [7:0]    char_q, char_d;
  kind_e         kind_q, kind_d;
  logic          last_q, last_d;
  logic          adv, emit;

  assign adv  = !ovalid_q || pop_i;
  assign emit = adv && !cmd_empty_i;
  assign cmd_pop_o = emit && last_d;

  always_comb begin
    last_d = (pos_q == cmd_last_pos_i);
    char_d = CH_NUL;
    kind_d = KIND_END_LINE;
    if (pos_q < PW'(cmd_nslash_i)) begin
      kind_d = KIND_CHAR;
      char_d = CH_BSLASH;
    end else if (pos_q == PW'(cmd_nslash_i)) begin
      case (cmd_tail_i)
        TAIL_CHAR: begin
          kind_d = KIND_CHAR;
          char_d = cmd_char_i;
        end
        TAIL_EARG, TAIL_EARG_ELINE: kind_d = KIND_END_ARG;
        default:                    kind_d = KIND_END_LINE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      pos_q    <= '0;
    end else begin
      if (emit) begin
        ovalid_q <= 1'b1;
        pos_q    <= last_d ? '0 : pos_q + 1'b1;
      end else if (pop_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= char_d;
      kind_q <= kind_d;
      last_q <= last_d;
    end
  end

  assign empty_o    = !ovalid_q;
  assign out_char_o = char_q;
  assign kind_o     = kind_q;
  assign last_o     = last_q;

endmodule

### hdl/command_line_argument_tokenizer_unit.sv
// Top level of the command line argument tokenizer.
//
//   channel  | handshake        | fields
//   ---------+------------------+---------------------------------
//   input    | push / full      | ch_i
//   result   | empty / pop      | out_char_o, kind_o, last_o
//
// One character is taken per cycle while the command queue has room.
// Each character yields at most one command; the back end emits one result
// per cycle while results are popped, and a command with N held backslashes
// yields N plus up to two results. The first result of a character passes
// through the command queue and the back end's output register to the outputs.
// Reset clears all parse state, the command queue and the output register.
module command_line_argument_tokenizer_unit import clat_pkg::*; #(
  parameter int RUN_LIMIT  = RUN_LIMIT_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  localparam int SW = $clog2(RUN_LIMIT + 1);
  localparam int PW = $clog2(RUN_LIMIT + 3);
  localparam int CMD_W = SW + PW + TAIL_W + 8;

  logic             accept;
  logic             cmd_valid;
  logic [SW-1:0]    f_nslash, b_nslash;
  logic [PW-1:0]    f_last_pos, b_last_pos;
  tail_e            f_tail, b_tail;
  logic [7:0]       f_char, b_char;
  logic [CMD_W-1:0] wdata, rdata;
  logic             q_full, q_empty, q_pop;

  assign accept = push && !q_full;
  assign full   = q_full;

  clat_front #(.RUN_LIMIT(RUN_LIMIT)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .ch_i,
    .cmd_valid_o    (cmd_valid),
    .cmd_nslash_o   (f_nslash),
    .cmd_last_pos_o (f_last_pos),
    .cmd_tail_o     (f_tail),
    .cmd_char_o     (f_char)
  );

  assign wdata = {f_nslash, f_last_pos, f_tail, f_char};

  clat_fifo #(.WIDTH(CMD_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_valid),
    .wdata_i (wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (rdata),
    .empty_o (q_empty)
  );

  assign b_nslash   = rdata[CMD_W-1 -: SW];
  assign b_last_pos = rdata[CMD_W-SW-1 -: PW];
  assign b_tail     = tail_e'(rdata[8 +: TAIL_W]);
  assign b_char     = rdata[7:0];

  clat_back #(.RUN_LIMIT(RUN_LIMIT)) u_back (
    .clk_i,
    .rst_ni,
    .cmd_empty_i    (q_empty),
    .cmd_nslash_i   (b_nslash),
    .cmd_last_pos_i (b_last_pos),
    .cmd_tail_i     (b_tail),
    .cmd_char_i     (b_char),
    .cmd_pop_o      (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_char_o,
    .kind_o,
    .last_o
  );

endmodule

### hdl/clat_checker.sv
// Port-level assertions for the tokenizer, bound to the top level.
module clat_checker import clat_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char_o,
  input logic [1:0] kind_o,
  input logic       last_o
);

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o == KIND_CHAR || kind_o == KIND_END_ARG || kind_o == KIND_END_LINE))
    else $error("illegal result kind");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_CHAR) |-> (out_char_o == CH_NUL))
    else $error("nonzero char on mark");

  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_END_LINE) |-> last_o)
    else $error("end of line not last");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(out_char_o)
                          && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind command_line_argument_tokenizer_unit clat_checker u_clat_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_char_o (out_char_o),
  .kind_o     (kind_o),
  .last_o     (last_o)
);

### dv/command_line_argument_tokenizer_unit_tb.sv
// Self-checking testbench for the command line argument tokenizer unit.
`timescale 1ns / 1ps

module command_line_argument_tokenizer_unit_tb;
  import clat_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned RX_HOLD_CYCLES = 150;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] chr;
    kind_e      kind;
    logic       last;
  } token_t;

  class token_scoreboard;
    token_t      expected_tokens[$];
    bit          in_arg;
    bit          in_quotes;
    bit          close_pending;
    logic [5:0]  held_slashes;
    int unsigned errors;

    function new();
      clear_line();
      errors = 0;
    endfunction

    function void clear_line();
      in_arg = 1'b0;
      in_quotes = 1'b0;
      close_pending = 1'b0;
      held_slashes = '0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function void add_token(kind_e k, logic [7:0] c);
      token_t t;
      t.chr = (k == KIND_CHAR) ? c : CH_NUL;
      t.kind = k;
      t.last = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function void flush_slashes(int unsigned n);
      for (int unsigned i = 0; i < n; i++) add_token(KIND_CHAR, CH_BSLASH);
    endfunction

    function void parse_arg_char(logic [7:0] c);
      if (c == CH_BSLASH) begin
        if (held_slashes < RUN_LIMIT_DEF) held_slashes++;
        return;
      end
      if (c == CH_DQUOTE) begin
        flush_slashes(held_slashes >> 1);
        if (held_slashes[0]) begin
          add_token(KIND_CHAR, CH_DQUOTE);
        end else if (in_quotes) begin
          close_pending = 1'b1;
        end else begin
          in_quotes = 1'b1;
        end
        held_slashes = '0;
        return;
      end
      flush_slashes(held_slashes);
      held_slashes = '0;
      if (c == CH_NUL) begin
        add_token(KIND_END_ARG, CH_NUL);
        add_token(KIND_END_LINE, CH_NUL);
        clear_line();
      end else if (!in_quotes && is_blank(c)) begin
        add_token(KIND_END_ARG, CH_NUL);
        in_arg = 1'b0;
      end else begin
        add_token(KIND_CHAR, c);
      end
    endfunction

    // Expected tokens for one accepted character.
    function void note_char(logic [7:0] c);
      int before_cnt;
      before_cnt = expected_tokens.size();
      if (close_pending) begin
        close_pending = 1'b0;
        in_quotes = 1'b0;
        if (c == CH_DQUOTE) add_token(KIND_CHAR, CH_DQUOTE);
        else parse_arg_char(c);
      end else if (!in_arg) begin
        if (c == CH_NUL) begin
          add_token(KIND_END_LINE, CH_NUL);
          clear_line();
        end else if (!is_blank(c)) begin
          in_arg = 1'b1;
          in_quotes = 1'b0;
          held_slashes = '0;
          parse_arg_char(c);
        end
      end else begin
        parse_arg_char(c);
      end
      if (expected_tokens.size() > before_cnt) begin
        expected_tokens[expected_tokens.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_token(logic [7:0] chr, logic [1:0] kind, logic last);
      token_t e;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected token: char %h kind %0d last %b", chr, kind, last);
        return;
      end
      e = expected_tokens.pop_front();
      if (chr !== e.chr || kind !== e.kind || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("token mismatch: expected char %h kind %0d last %b, got char %h kind %0d last %b",
                   e.chr, e.kind, e.last, chr, kind, last);
      end
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic [7:0] ch_i = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_char_o;
  logic [1:0] kind_o;
  logic       last_o;

  token_scoreboard sb = new();
  int unsigned     n_sent = 0;
  int unsigned     burst_left = 0;
  int unsigned     idle_cycles = 0;
  bit              hold_rx = 1'b0;

  command_line_argument_tokenizer_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .ch_i      (ch_i),
    .empty     (empty),
    .pop       (pop),
    .out_char_o(out_char_o),
    .kind_o    (kind_o),
    .last_o    (last_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_char(ch_i);
      if (pop && !empty) sb.check_token(out_char_o, kind_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: rotating stall pattern, plus one long hold-off on request.
  initial begin
    int unsigned rx_cyc;
    rx_cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      rx_cyc++;
      case ((rx_cyc / 40) % 4)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 1) == 1);
        2: pop <= (rx_cyc % 4 == 0);
        default: pop <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic feed(input logic [7:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
    end
    burst_left--;
    ch_i <= c;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    n_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic send_line(input bit long_run);
    int unsigned ntok;
    int unsigned pick;
    if (long_run) repeat ($urandom_range(RUN_LIMIT_DEF + 1, RUN_LIMIT_DEF + 8)) feed(CH_BSLASH);
    ntok = $urandom_range(1, 12);
    for (int unsigned t = 0; t < ntok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        feed(8'($urandom_range(8'h61, 8'h7A)));
      end else if (pick < 45) begin
        feed(8'($urandom_range(1, 255)));
      end else if (pick < 60) begin
        case ($urandom_range(0, 3))
          0: feed(CH_SPACE);
          1: feed(CH_TAB);
          2: feed(CH_CR);
          default: feed(CH_LF);
        endcase
      end else if (pick < 75) begin
        feed(CH_DQUOTE);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 5)) feed(CH_BSLASH);
      end else if (pick < 98) begin
        feed(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(RUN_LIMIT_DEF - 2, RUN_LIMIT_DEF + 8)) feed(CH_BSLASH);
      end
    end
    // some lines run on unterminated into the next one
    if ($urandom_range(0, 9) != 0) feed(CH_NUL);
  endtask

  initial begin
    int unsigned n_directed;
    bit          hold_done;
    bit          pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty line
    feed(CH_NUL);
    // extreme bytes, tab, carriage return and line feed separators
    feed(8'hFF); feed(CH_TAB); feed(8'h01); feed(CH_CR); feed(CH_LF);
    // quoted blank, doubled quote closing the quotes
    feed(CH_DQUOTE); feed(CH_SPACE); feed(CH_DQUOTE); feed(CH_DQUOTE); feed(8'h7A);
    // empty quoted section, close decided by a separator
    feed(CH_DQUOTE); feed(CH_DQUOTE); feed(CH_SPACE);
    // even run toggles, odd run escapes, plain run copied, held run at end of line
    feed(CH_BSLASH); feed(CH_BSLASH); feed(CH_DQUOTE); feed(CH_BSLASH); feed(CH_DQUOTE);
    feed(CH_BSLASH); feed(8'h61); feed(CH_BSLASH); feed(CH_NUL);
    n_directed = n_sent;

    send_line(1'b1);
    while (n_sent < n_directed + RANDOM_ITEMS) begin
      if (!hold_done && n_sent >= n_directed + 100) begin
        hold_rx = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && n_sent >= n_directed + 220) begin
        drain();
        pause_done = 1'b1;
      end
      send_line(1'b0);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
